[rtl/core/greedy_two_way_partition_macros.svh]
// ----------------------------------------------------------------------------
// greedy_two_way_partition_macros
// Assertion macros shared by the partitioning block.
// ----------------------------------------------------------------------------
`ifndef GREEDY_TWO_WAY_PARTITION_MACROS_SVH
`define GREEDY_TWO_WAY_PARTITION_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define GTWP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("gtwp invariant violated");

// A condition that must hold in the cycle after a trigger.
`define GTWP_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("gtwp sequence violated");

`endif

[rtl/core/gtwp_pkg.sv]
// ----------------------------------------------------------------------------
// gtwp_pkg
// Types and constants shared by the greedy two-way partitioning block.
// ----------------------------------------------------------------------------
`default_nettype none

package gtwp_pkg;

    // Width of one weight on the input stream and in the store.
    localparam int WEIGHT_BITS = 16;

    // Default number of weights that the store holds.
    localparam int MAX_ITEMS_DEF = 64;

    // Width of the difference field and of the padded output data bus.
    localparam int DIFF_BITS   = 22;
    localparam int OUT_TDATA_W = 24;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_DEAL_RD,
        ST_DEAL_UPD,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

[rtl/core/greedy_two_way_partition.sv]
// A weight is taken in ST_IDLE only; s_tready stays low while it is inserted, each
// shifted stored entry taking an ST_INS_RD and an ST_INS_CMP step, and the weight is
// written in ST_INS_CMP, or in ST_INS_RD when it lands in the first entry. A set is then
// dealt one weight at a time (ST_DEAL_RD, ST_DEAL_UPD) and ST_FINISH posts the result.
// The result waits in an output register while the next set is already loaded.
// Reset (rst_n, asynchronous, active low) empties the set; store contents stay undefined.
// ----------------------------------------------------------------------------
// greedy_two_way_partition
// Sorts incoming weights in descending order and deals them greedily into two
// bins, then reports the absolute difference of the bin sums once per set.
// ----------------------------------------------------------------------------
`default_nettype none
`include "greedy_two_way_partition_macros.svh"

module greedy_two_way_partition #(
    parameter int MAX_ITEMS = gtwp_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // s_tdata: weight [15:0]
    input  wire logic [gtwp_pkg::WEIGHT_BITS-1:0]   s_tdata,
    input  wire logic                               s_tlast,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // m_tdata: difference [21:0], zero padding [23:22]
    output logic      [gtwp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // m_tuser: overflowed [0]
    output logic                                    m_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready
);

    localparam int WB     = gtwp_pkg::WEIGHT_BITS;
    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int PAD_W  = gtwp_pkg::OUT_TDATA_W - gtwp_pkg::DIFF_BITS;

    gtwp_pkg::state_t state_reg, state_next;

    logic [WB-1:0]    w_reg, w_next;
    logic             last_reg, last_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [WB-1:0]    diff_reg, diff_next;
    logic             dropped_reg, dropped_next;
    logic             out_valid_reg, out_valid_next;
    logic [gtwp_pkg::DIFF_BITS-1:0] out_diff_reg, out_diff_next;
    logic             out_ovf_reg, out_ovf_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WB-1:0]     ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WB-1:0]     ram_rdata;

    logic             in_xfer;
    logic             out_xfer;
    logic             store_full;
    logic             shift_up;
    logic             out_free;
    logic [WB-1:0]    abs_diff;
    logic [CNT_W-1:0] k_inc;

    assign in_xfer    = s_tvalid && s_tready;
    assign out_xfer   = out_valid_reg && m_tready;
    assign store_full = (count_reg == CNT_W'(MAX_ITEMS));
    assign shift_up   = (ram_rdata < w_reg);
    assign out_free   = !out_valid_reg || m_tready;
    assign k_inc      = k_reg + CNT_W'(1);

    // Absolute difference of the running imbalance and one weight.
    assign abs_diff = (diff_reg >= ram_rdata) ? (diff_reg - ram_rdata)
                                              : (ram_rdata - diff_reg);

    // Sort store.
    gtwp_ram #(
        .DATA_W (WB),
        .DEPTH  (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gtwp_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (!store_full)
                        state_next = gtwp_pkg::ST_INS_RD;
                    else if (s_tlast)
                        state_next = gtwp_pkg::ST_DEAL_RD;
                end
            end
            gtwp_pkg::ST_INS_RD:
            begin
                if (pos_reg == '0)
                    state_next = last_reg ? gtwp_pkg::ST_DEAL_RD : gtwp_pkg::ST_IDLE;
                else
                    state_next = gtwp_pkg::ST_INS_CMP;
            end
            gtwp_pkg::ST_INS_CMP:
            begin
                if (shift_up)
                    state_next = gtwp_pkg::ST_INS_RD;
                else
                    state_next = last_reg ? gtwp_pkg::ST_DEAL_RD : gtwp_pkg::ST_IDLE;
            end
            gtwp_pkg::ST_DEAL_RD:
            begin
                state_next = gtwp_pkg::ST_DEAL_UPD;
            end
            gtwp_pkg::ST_DEAL_UPD:
            begin
                state_next = (k_inc == count_reg) ? gtwp_pkg::ST_FINISH
                                                  : gtwp_pkg::ST_DEAL_RD;
            end
            gtwp_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = gtwp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gtwp_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake and memory controls.
    always_comb
    begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = pos_reg[ADDR_W-1:0];
        ram_wdata = w_reg;
        ram_raddr = k_reg[ADDR_W-1:0];
        case (state_reg)
            gtwp_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            gtwp_pkg::ST_INS_RD:
            begin
                ram_we    = (pos_reg == '0);
                ram_raddr = ADDR_W'(pos_reg - CNT_W'(1));
            end
            gtwp_pkg::ST_INS_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = shift_up ? ram_rdata : w_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Datapath updates.
    always_comb
    begin
        w_next         = w_reg;
        last_next      = last_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        diff_next      = diff_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_xfer ? 1'b0 : out_valid_reg;
        out_diff_next  = out_diff_reg;
        out_ovf_next   = out_ovf_reg;
        case (state_reg)
            gtwp_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    w_next    = s_tdata;
                    last_next = s_tlast;
                    pos_next  = count_reg;
                    if (store_full)
                        dropped_next = 1'b1;
                end
            end
            gtwp_pkg::ST_INS_RD:
            begin
                if (pos_reg == '0)
                    count_next = count_reg + CNT_W'(1);
            end
            gtwp_pkg::ST_INS_CMP:
            begin
                if (shift_up)
                    pos_next = pos_reg - CNT_W'(1);
                else
                    count_next = count_reg + CNT_W'(1);
            end
            gtwp_pkg::ST_DEAL_UPD:
            begin
                // The next weight goes to the lighter bin, so the imbalance
                // becomes the distance between it and the weight.
                diff_next = abs_diff;
                k_next    = k_inc;
            end
            gtwp_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_diff_next  = gtwp_pkg::DIFF_BITS'(diff_reg);
                    out_ovf_next   = dropped_reg;
                    count_next     = '0;
                    k_next         = '0;
                    diff_next      = '0;
                    dropped_next   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gtwp_pkg::ST_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            diff_reg      <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            diff_reg      <= diff_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        last_reg     <= last_next;
        pos_reg      <= pos_next;
        out_diff_reg <= out_diff_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_diff_reg};
    assign m_tuser  = out_ovf_reg;

    // Checks on the sequencer.
    `GTWP_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(MAX_ITEMS))
    `GTWP_ASSERT_ALWAYS(a_pos_bound,
        (state_reg != gtwp_pkg::ST_INS_CMP) || (pos_reg != '0 && pos_reg <= count_reg))
    `GTWP_ASSERT_NEXT(a_set_cleared,
        state_reg == gtwp_pkg::ST_FINISH && out_free,
        count_reg == '0 && !dropped_reg && m_tvalid)

endmodule

`default_nettype wire

[rtl/core/gtwp_ram.sv]
// ----------------------------------------------------------------------------
// gtwp_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gtwp_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
